FILE: rtl/sip_pkg.sv
package sip_pkg;

	localparam int CB = 16;
	localparam int FB = 8;
	localparam int OW = CB + FB;
	localparam int DW = CB + 1;
	localparam int PW = 2 * DW;
	localparam int XW = PW + 1;
	localparam int MW = DW + XW;
	localparam int SW = MW + 1;
	localparam int NW = SW + FB;
	localparam int QW = OW;
	localparam int RW = XW + 1;
	localparam int NX = 6;

	localparam int X_ABC = 0;
	localparam int X_ABD = 1;
	localparam int X_CDA = 2;
	localparam int X_CDB = 3;
	localparam int X_DET = 4;
	localparam int X_NUM = 5;

	typedef struct packed {
		logic signed [CB-1:0] ax;
		logic signed [CB-1:0] ay;
		logic signed [CB-1:0] bx;
		logic signed [CB-1:0] by;
		logic signed [CB-1:0] cx;
		logic signed [CB-1:0] cy;
		logic signed [CB-1:0] dx;
		logic signed [CB-1:0] dy;
	} seg_t;

	typedef struct packed {
		logic                 hit;
		logic                 point_valid;
		logic signed [OW-1:0] px;
		logic signed [OW-1:0] py;
	} pt_t;

	typedef struct packed {
		logic [1:0][RW-1:0] r;
		logic [1:0][QW-1:0] nl;
		logic [1:0][QW-1:0] q;
		logic [1:0]         neg;
		logic [XW-1:0]      dm;
		logic               hit;
		logic               pv;
	} dv_t;

endpackage

FILE: rtl/segment_intersection_point.sv
// Segment intersection test with crossing point.
// A beat on the seg channel carries two segments AB and CD with signed
// 16-bit endpoints. For each beat one beat leaves on the pt channel: hit
// tells whether the segments touch or cross, and point_valid with px and py
// gives the crossing point with 8 fraction bits when hit is set and the
// determinant is nonzero. When point_valid is low, px and py are zero.
// The block is a 30-stage pipeline: five stages of differences, cross
// products, orientation tests and point numerators, then one quotient bit
// per stage for 24 stages, then the output register. One beat is taken in
// every cycle while seg_stall is low.
// Each stage holds its own valid bit and moves whenever the stage after it
// is empty or moving, so bubbles close up while pt_stall is high; seg_stall
// rises only when every stage holds an item and the output is stalled.
// Reset clears all valid bits; no result is lost or repeated under stall.
module segment_intersection_point (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          seg_valid,
	output logic          seg_stall,
	input  sip_pkg::seg_t seg,
	output logic          pt_valid,
	input  logic          pt_stall,
	output sip_pkg::pt_t  pt
);
	import sip_pkg::*;

	function automatic logic lex_less(input logic signed [CB-1:0] x1,
		input logic signed [CB-1:0] y1, input logic signed [CB-1:0] x2,
		input logic signed [CB-1:0] y2);
		lex_less = (x1 < x2) || ((x1 == x2) && (y1 < y2));
	endfunction

	function automatic dv_t div_step(input dv_t d);
		dv_t o;
		logic [RW-1:0] t;
		o = d;
		for (int j = 0; j < 2; j++) begin
			t = {d.r[j][RW-2:0], d.nl[j][QW-1]};
			if (t >= {1'b0, d.dm}) begin
				o.r[j] = t - {1'b0, d.dm};
				o.q[j] = {d.q[j][QW-2:0], 1'b1};
			end else begin
				o.r[j] = t;
				o.q[j] = {d.q[j][QW-2:0], 1'b0};
			end
			o.nl[j] = {d.nl[j][QW-2:0], 1'b0};
		end
		div_step = o;
	endfunction

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                 ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_res;
	seg_t                 sg_s1, sg_s2, sg_s3;
	logic signed [DW-1:0] ux_s1 [NX];
	logic signed [DW-1:0] uy_s1 [NX];
	logic signed [DW-1:0] vx_s1 [NX];
	logic signed [DW-1:0] vy_s1 [NX];
	logic signed [PW-1:0] p_s2 [NX];
	logic signed [PW-1:0] q_s2 [NX];
	logic signed [DW-1:0] bax_s2, bay_s2, bax_s3, bay_s3;
	logic signed [XW-1:0] cr [NX];
	logic signed [XW-1:0] det_s3, num_s3, det_s4;
	logic                 hit_s3, pv_s3, hit_s4, pv_s4, hit_s5, pv_s5;
	logic signed [MW-1:0] ad_s4 [2];
	logic signed [MW-1:0] dn_s4 [2];
	logic [NW-1:0]        nm_s5 [2];
	logic [1:0]           neg_s5;
	logic [XW-1:0]        dm_s5;
	logic [1:0]           sg3 [4];
	logic                 ab_zero, cd_zero, ab_le, cd_le, coll_hit;
	logic signed [CB-1:0] lx, ly, hx, hy, mx, my, kx, ky;
	logic signed [SW-1:0] sm [2];
	logic [SW-1:0]        smag [2];
	dv_t                  dv_init;
	dv_t                  dv_s [QW];
	logic [QW-1:0]        dv_v;
	logic [QW-1:0]        ld_dv;
	logic                 res_v_q;
	pt_t                  res_q;
	logic [QW-1:0]        qx, qy;

	assign ld_res = !res_v_q || !pt_stall;
	assign ld_s5 = !v_s5 || ld_dv[0];
	assign ld_s4 = !v_s4 || ld_s5;
	assign ld_s3 = !v_s3 || ld_s4;
	assign ld_s2 = !v_s2 || ld_s3;
	assign ld_s1 = !v_s1 || ld_s2;
	assign seg_stall = !ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= seg_valid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
			if (ld_s4) v_s4 <= v_s3;
			if (ld_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			sg_s1 <= seg;
			ux_s1[X_ABC] <= DW'(seg.bx) - DW'(seg.ax);
			uy_s1[X_ABC] <= DW'(seg.by) - DW'(seg.ay);
			vx_s1[X_ABC] <= DW'(seg.cx) - DW'(seg.ax);
			vy_s1[X_ABC] <= DW'(seg.cy) - DW'(seg.ay);
			ux_s1[X_ABD] <= DW'(seg.bx) - DW'(seg.ax);
			uy_s1[X_ABD] <= DW'(seg.by) - DW'(seg.ay);
			vx_s1[X_ABD] <= DW'(seg.dx) - DW'(seg.ax);
			vy_s1[X_ABD] <= DW'(seg.dy) - DW'(seg.ay);
			ux_s1[X_CDA] <= DW'(seg.dx) - DW'(seg.cx);
			uy_s1[X_CDA] <= DW'(seg.dy) - DW'(seg.cy);
			vx_s1[X_CDA] <= DW'(seg.ax) - DW'(seg.cx);
			vy_s1[X_CDA] <= DW'(seg.ay) - DW'(seg.cy);
			ux_s1[X_CDB] <= DW'(seg.dx) - DW'(seg.cx);
			uy_s1[X_CDB] <= DW'(seg.dy) - DW'(seg.cy);
			vx_s1[X_CDB] <= DW'(seg.bx) - DW'(seg.cx);
			vy_s1[X_CDB] <= DW'(seg.by) - DW'(seg.cy);
			ux_s1[X_DET] <= DW'(seg.bx) - DW'(seg.ax);
			uy_s1[X_DET] <= DW'(seg.by) - DW'(seg.ay);
			vx_s1[X_DET] <= DW'(seg.dx) - DW'(seg.cx);
			vy_s1[X_DET] <= DW'(seg.dy) - DW'(seg.cy);
			ux_s1[X_NUM] <= DW'(seg.cx) - DW'(seg.ax);
			uy_s1[X_NUM] <= DW'(seg.cy) - DW'(seg.ay);
			vx_s1[X_NUM] <= DW'(seg.dx) - DW'(seg.cx);
			vy_s1[X_NUM] <= DW'(seg.dy) - DW'(seg.cy);
		end
		if (ld_s2) begin
			sg_s2 <= sg_s1;
			bax_s2 <= ux_s1[X_DET];
			bay_s2 <= uy_s1[X_DET];
			for (int i = 0; i < NX; i++) begin
				p_s2[i] <= PW'(ux_s1[i]) * PW'(vy_s1[i]);
				q_s2[i] <= PW'(uy_s1[i]) * PW'(vx_s1[i]);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NX; i++) begin
			cr[i] = XW'(p_s2[i]) - XW'(q_s2[i]);
		end
		for (int i = 0; i < 4; i++) begin
			sg3[i] = {cr[i][XW-1], cr[i] != '0};
		end
		ab_zero = !sg3[X_ABC][0] || !sg3[X_ABD][0];
		cd_zero = !sg3[X_CDA][0] || !sg3[X_CDB][0];
		ab_le = ab_zero || (sg3[X_ABC][1] != sg3[X_ABD][1]);
		cd_le = cd_zero || (sg3[X_CDA][1] != sg3[X_CDB][1]);
		lx = sg_s2.ax;
		ly = sg_s2.ay;
		hx = sg_s2.bx;
		hy = sg_s2.by;
		if (lex_less(sg_s2.bx, sg_s2.by, sg_s2.ax, sg_s2.ay)) begin
			lx = sg_s2.bx;
			ly = sg_s2.by;
			hx = sg_s2.ax;
			hy = sg_s2.ay;
		end
		mx = sg_s2.cx;
		my = sg_s2.cy;
		kx = sg_s2.dx;
		ky = sg_s2.dy;
		if (lex_less(sg_s2.dx, sg_s2.dy, sg_s2.cx, sg_s2.cy)) begin
			mx = sg_s2.dx;
			my = sg_s2.dy;
			kx = sg_s2.cx;
			ky = sg_s2.cy;
		end
		coll_hit = !(lex_less(hx, hy, mx, my) || lex_less(kx, ky, lx, ly));
	end

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			sg_s3 <= sg_s2;
			bax_s3 <= bax_s2;
			bay_s3 <= bay_s2;
			det_s3 <= cr[X_DET];
			num_s3 <= cr[X_NUM];
			hit_s3 <= (ab_zero && cd_zero) ? coll_hit : (ab_le && cd_le);
			pv_s3 <= ((ab_zero && cd_zero) ? coll_hit : (ab_le && cd_le))
				&& (cr[X_DET] != '0);
		end
		if (ld_s4) begin
			det_s4 <= det_s3;
			hit_s4 <= hit_s3;
			pv_s4 <= pv_s3;
			ad_s4[0] <= MW'(sg_s3.ax) * MW'(det_s3);
			ad_s4[1] <= MW'(sg_s3.ay) * MW'(det_s3);
			dn_s4[0] <= MW'(bax_s3) * MW'(num_s3);
			dn_s4[1] <= MW'(bay_s3) * MW'(num_s3);
		end
	end

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			sm[j] = SW'(ad_s4[j]) + SW'(dn_s4[j]);
			smag[j] = sm[j][SW-1] ? SW'(-sm[j]) : SW'(sm[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s5) begin
			hit_s5 <= hit_s4;
			pv_s5 <= pv_s4;
			dm_s5 <= det_s4[XW-1] ? XW'(-det_s4) : XW'(det_s4);
			for (int j = 0; j < 2; j++) begin
				nm_s5[j] <= {smag[j], FB'(0)};
				neg_s5[j] <= sm[j][SW-1] ^ det_s4[XW-1];
			end
		end
	end

	always_comb begin
		dv_init.hit = hit_s5;
		dv_init.pv = pv_s5;
		dv_init.dm = dm_s5;
		dv_init.neg = neg_s5;
		for (int j = 0; j < 2; j++) begin
			dv_init.r[j] = RW'(nm_s5[j] >> QW);
			dv_init.nl[j] = nm_s5[j][QW-1:0];
			dv_init.q[j] = '0;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic vin;
		dv_t  din;
		if (k == 0) begin : g_first
			assign vin = v_s5;
			assign din = dv_init;
		end else begin : g_next
			assign vin = dv_v[k-1];
			assign din = dv_s[k-1];
		end
		if (k == QW - 1) begin : g_last
			assign ld_dv[k] = !dv_v[k] || ld_res;
		end else begin : g_mid
			assign ld_dv[k] = !dv_v[k] || ld_dv[k+1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k] <= 1'b0;
			end else if (ld_dv[k]) begin
				dv_v[k] <= vin;
			end
		end
		always_ff @(posedge clk) begin
			if (ld_dv[k]) dv_s[k] <= div_step(din);
		end
	end

	assign qx = dv_s[QW-1].q[0];
	assign qy = dv_s[QW-1].q[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (ld_res) begin
			res_v_q <= dv_v[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ld_res) begin
			res_q.hit <= dv_s[QW-1].hit;
			res_q.point_valid <= dv_s[QW-1].pv;
			if (dv_s[QW-1].pv) begin
				res_q.px <= dv_s[QW-1].neg[0] ? OW'(-qx) : OW'(qx);
				res_q.py <= dv_s[QW-1].neg[1] ? OW'(-qy) : OW'(qy);
			end else begin
				res_q.px <= '0;
				res_q.py <= '0;
			end
		end
	end

	assign pt_valid = res_v_q;
	assign pt = res_q;

	a_pv_implies_hit: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && pt.point_valid |-> pt.hit)
		else $error("point_valid without hit");

	a_no_point_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !pt.point_valid |-> (pt.px == '0) && (pt.py == '0))
		else $error("point fields not cleared");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		seg_stall |-> v_s1 && pt_valid && pt_stall)
		else $error("input stalled with room in the pipeline");

endmodule

FILE: test/segment_intersection_point_test.sv
`timescale 1ns / 100ps

module segment_intersection_point_test;
	import sip_pkg::*;

	class point_scoreboard;
		pt_t pending_points[$];
		int mismatches = 0;

		static function longint cross_prod(longint ux, longint uy, longint vx, longint vy);
			return ux * vy - uy * vx;
		endfunction

		static function int sgn(longint v);
			return (v > 0) - (v < 0);
		endfunction

		static function bit lex_less(longint x1, longint y1, longint x2, longint y2);
			return x1 < x2 || (x1 == x2 && y1 < y2);
		endfunction

		static function logic [OW-1:0] fixed_coord(longint a, longint diff, longint num,
				longint det);
			logic signed [127:0] wa, wd, wn, wt, total;
			wa = a;
			wd = diff;
			wn = num;
			wt = det;
			total = (wa * wt + wd * wn) * 256;
			total = total / wt;
			return total[OW-1:0];
		endfunction

		static function pt_t expected_point(seg_t s);
			longint ax, ay, bx, by, cx, cy, dx, dy, det, num, t;
			longint lx, ly, hx, hy, mx, my, kx, ky;
			int ab, cd;
			bit hit;
			pt_t r;
			ax = s.ax; ay = s.ay; bx = s.bx; by = s.by;
			cx = s.cx; cy = s.cy; dx = s.dx; dy = s.dy;
			ab = sgn(cross_prod(bx - ax, by - ay, cx - ax, cy - ay))
				* sgn(cross_prod(bx - ax, by - ay, dx - ax, dy - ay));
			cd = sgn(cross_prod(dx - cx, dy - cy, ax - cx, ay - cy))
				* sgn(cross_prod(dx - cx, dy - cy, bx - cx, by - cy));
			if (ab == 0 && cd == 0) begin
				lx = ax; ly = ay; hx = bx; hy = by;
				mx = cx; my = cy; kx = dx; ky = dy;
				if (lex_less(hx, hy, lx, ly)) begin
					t = lx; lx = hx; hx = t;
					t = ly; ly = hy; hy = t;
				end
				if (lex_less(kx, ky, mx, my)) begin
					t = mx; mx = kx; kx = t;
					t = my; my = ky; ky = t;
				end
				hit = !(lex_less(hx, hy, mx, my) || lex_less(kx, ky, lx, ly));
			end else begin
				hit = ab <= 0 && cd <= 0;
			end
			det = cross_prod(bx - ax, by - ay, dx - cx, dy - cy);
			num = cross_prod(cx - ax, cy - ay, dx - cx, dy - cy);
			r.hit = hit;
			r.point_valid = hit && det != 0;
			r.px = r.point_valid ? fixed_coord(ax, bx - ax, num, det) : '0;
			r.py = r.point_valid ? fixed_coord(ay, by - ay, num, det) : '0;
			return r;
		endfunction

		function void note_segments(seg_t s);
			pending_points.push_back(expected_point(s));
		endfunction

		function void check_point(pt_t got);
			pt_t want;
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: %p", got);
				return;
			end
			want = pending_points.pop_front();
			if (got.hit !== want.hit || got.point_valid !== want.point_valid
					|| got.px !== want.px || got.py !== want.py) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result differs: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic seg_valid = 1'b0;
	logic seg_stall;
	seg_t seg = '0;
	logic pt_valid;
	logic pt_stall = 1'b0;
	pt_t pt;

	point_scoreboard sb = new();
	int cycle = 0;
	int quiet_cycles = 0;

	segment_intersection_point dut (
		.clk(clk),
		.arst_n(arst_n),
		.seg_valid(seg_valid),
		.seg_stall(seg_stall),
		.seg(seg),
		.pt_valid(pt_valid),
		.pt_stall(pt_stall),
		.pt(pt)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			cycle <= cycle + 1;
			if (pt_valid && !pt_stall)
				sb.check_point(pt);
			if ((pt_valid && !pt_stall) || (seg_valid && !seg_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= 3000) begin
				$display("segment_intersection_point: mismatch");
				$finish;
			end
			if (cycle > 400 && cycle < 700)
				pt_stall <= 1'b0;
			else
				pt_stall <= $urandom_range(99) < 28;
		end
	end

	function automatic seg_t make_seg(int ax, int ay, int bx, int by, int cx, int cy,
			int dx, int dy);
		seg_t s;
		s.ax = CB'(ax); s.ay = CB'(ay); s.bx = CB'(bx); s.by = CB'(by);
		s.cx = CB'(cx); s.cy = CB'(cy); s.dx = CB'(dx); s.dy = CB'(dy);
		return s;
	endfunction

	function automatic int near(int r);
		return int'($urandom_range(2 * r)) - r;
	endfunction

	function automatic seg_t random_segments();
		seg_t s;
		int px, py, ux, uy;
		case ($urandom_range(4))
			0: s = seg_t'({$urandom, $urandom, $urandom, $urandom});
			1: s = make_seg(near(20), near(20), near(20), near(20),
				near(20), near(20), near(20), near(20));
			2: begin
				px = near(30000); py = near(30000);
				ux = near(100); uy = near(100);
				s = make_seg(px, py, px + near(10) * ux, py + near(10) * uy,
					px + near(10) * ux, py + near(10) * uy,
					px + near(10) * ux, py + near(10) * uy);
			end
			3: begin
				s = seg_t'({$urandom, $urandom, $urandom, $urandom});
				if ($urandom_range(1)) begin
					s.cx = s.ax; s.cy = s.ay;
				end else begin
					s.dx = s.bx; s.dy = s.by;
				end
			end
			default: s = make_seg(near(1000), near(1000), near(1000), near(1000),
				near(1000), near(1000), near(1000), near(1000));
		endcase
		return s;
	endfunction

	task automatic send_segments(seg_t s, bit may_idle);
		seg_valid <= 1'b1;
		seg <= s;
		do @(posedge clk); while (seg_stall);
		sb.note_segments(s);
		if (may_idle) begin
			while ($urandom_range(99) < 28) begin
				seg_valid <= 1'b0;
				seg <= random_segments();
				@(posedge clk);
			end
		end
	endtask

	initial begin
		seg_t directed[$];
		directed.push_back(make_seg(0, 0, 10, 10, 0, 10, 10, 0));
		directed.push_back(make_seg(0, 0, 10, 0, 0, 1, 10, 1));
		directed.push_back(make_seg(0, 0, 10, 0, 5, 0, 20, 0));
		directed.push_back(make_seg(0, 0, 10, 0, 11, 0, 20, 0));
		directed.push_back(make_seg(10, 0, 0, 0, 20, 0, 10, 0));
		directed.push_back(make_seg(0, 0, 0, 10, 0, 5, 0, -3));
		directed.push_back(make_seg(0, 0, 10, 10, 10, 10, 20, 0));
		directed.push_back(make_seg(0, 0, 10, 0, 5, 0, 5, 7));
		directed.push_back(make_seg(3, 3, 3, 3, 3, 3, 3, 3));
		directed.push_back(make_seg(3, 3, 3, 3, 0, 0, 6, 6));
		directed.push_back(make_seg(3, 3, 3, 3, 4, 4, 4, 4));
		directed.push_back(make_seg(3, 4, 3, 4, 0, 0, 6, 6));
		directed.push_back(make_seg(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
		directed.push_back(make_seg(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
		directed.push_back(make_seg(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
		directed.push_back(make_seg(0, 0, 3, 7, 0, 5, 2, -1));
		directed.push_back(make_seg(0, 0, -3, -7, -1, -5, -2, 1));
		directed.push_back(make_seg(-32768, -32768, -32768, 32767, -32768, 0, -32768, 5));
		directed.push_back(make_seg(32767, 32767, 32767, 32767, 32767, 32767, 0, 0));
		directed.push_back(make_seg(0, 0, 1, 1, 5, 6, 7, 9));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_segments(directed[i], 1'b1);
		for (int i = 0; i < 750; i++) begin
			if (i == 500) begin
				seg_valid <= 1'b0;
				while (sb.pending_points.size() != 0)
					@(posedge clk);
			end
			send_segments(random_segments(), i < 300 || i > 450);
		end
		seg_valid <= 1'b0;
		while (sb.pending_points.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0)
			$display("segment_intersection_point: match");
		else
			$display("segment_intersection_point: mismatch");
		$finish;
	end
endmodule
